FILE: rtl/indexed_min_heap_timer_queue_macros.svh
// assertion macros used by the checker file
// no dependencies; expects aclk and aresetn in the including scope
`ifndef INDEXED_MIN_HEAP_TIMER_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, off during reset
`define IHTQ_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("ihtq assertion failed");

// next-cycle implication, off during reset
`define IHTQ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("ihtq assertion failed");

`endif

FILE: rtl/ihtq_pkg.sv
// types and codes for the indexed min-heap timer queue
// no dependencies
package ihtq_pkg;

    localparam int HANDLE_W = 8;
    localparam int KEY_IN_W = 32;
    localparam int COUNT_W  = 9;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_QUEUED = 3'd4;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_IN_W-1:0] key;
    } in_beat_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic [KEY_IN_W-1:0] out_key;
        logic [2:0]          status;
        logic [COUNT_W-1:0]  entry_count;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_UP_CMP,
        S_POP_ROOT,
        S_DEL_POS,
        S_DEL_SLOT,
        S_LOAD_LAST,
        S_DOWN,
        S_DN_RIGHT,
        S_DN_CMP,
        S_PLACE,
        S_RESP
    } seq_state_t;

endpackage

FILE: rtl/ihtq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ihtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/indexed_min_heap_timer_queue.sv
// Indexed min-heap timer queue: push, pop-minimum and delete-by-handle.
// Input beats on s_valid/s_ready/s_data, one result beat per input on
// m_valid/m_ready/m_data. Heap slots and the handle position map sit in
// ihtq_ram instances; queued flags are flip-flops cleared by reset.
// One operation at a time: s_ready is high only in the idle state.
// Every step does at most one slot ram read, so the work follows the
// heap path: push climbs from the new last slot, pop descends from the
// root, and delete climbs or descends from the deleted slot.
// Errors (empty, full, absent, already queued) go from the check straight to the result.
// The result sits in an output register: a new input is taken while it
// waits, and the next result holds in the sequencer until m_ready frees it.
// aresetn (synchronous, active low) empties the queue and clears all
// queued flags; heap and position rams are not cleared, no clearing pass.
module indexed_min_heap_timer_queue
    import ihtq_pkg::*;
#(
    parameter int HEAP_DEPTH   = 256,
    parameter int HANDLE_COUNT = 256,
    parameter int KEY_WIDTH    = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int PW  = $clog2(HEAP_DEPTH);
    localparam int HW  = $clog2(HANDLE_COUNT);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int XW  = PW + 2;
    localparam int SW  = KEY_WIDTH + HANDLE_W;

    seq_state_t state_reg, state_next;

    logic [1:0]           mode_reg, mode_next;
    logic [HANDLE_W-1:0]  h_reg, h_next;
    logic [KEY_WIDTH-1:0] kin_reg, kin_next;
    logic [PW-1:0]        hole_reg, hole_next;
    logic [KEY_WIDTH-1:0] cur_key_reg, cur_key_next;
    logic [HANDLE_W-1:0]  cur_h_reg, cur_h_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [HANDLE_W-1:0]  res_h_reg, res_h_next;
    logic [KEY_WIDTH-1:0] res_k_reg, res_k_next;
    logic [2:0]           st_reg, st_next;
    logic                 del_first_reg, del_first_next;
    logic                 two_reg, two_next;
    logic [SW-1:0]        right_reg, right_next;
    logic                 out_valid_reg;
    out_beat_t            out_reg;
    logic [HANDLE_COUNT-1:0] queued_reg;

    logic          q_set, q_clr;
    logic [HW-1:0] q_set_idx, q_clr_idx;

    logic          slot_we;
    logic [PW-1:0] slot_waddr, slot_raddr;
    logic [SW-1:0] slot_wdata, slot_rdata;
    logic          pos_we;
    logic [HW-1:0] pos_waddr, pos_raddr;
    logic [PW-1:0] pos_wdata, pos_rdata;

    logic [KEY_WIDTH-1:0] rd_key, right_key;
    logic [HANDLE_W-1:0]  rd_h;
    logic [PW-1:0]        parent;
    logic [XW-1:0]        child_r, n_ext;
    logic                 in_range, is_queued, pick_right;
    logic [SW-1:0]        pick;
    logic [PW-1:0]        pick_idx;
    logic [CW-1:0]        count_dec;

    ihtq_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ihtq_ram #(.WIDTH(PW), .DEPTH(HANDLE_COUNT)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    assign rd_key     = slot_rdata[SW-1:HANDLE_W];
    assign rd_h       = slot_rdata[HANDLE_W-1:0];
    assign right_key  = right_reg[SW-1:HANDLE_W];
    assign parent     = PW'((hole_reg - PW'(1)) >> 1);
    assign child_r    = (XW'(hole_reg) << 1) + XW'(2);
    assign n_ext      = XW'(count_reg);
    assign count_dec  = count_reg - CW'(1);
    assign in_range   = 32'(h_reg) < 32'(HANDLE_COUNT);
    assign is_queued  = queued_reg[HW'(h_reg)];
    assign pick_right = two_reg && !(right_key > rd_key);
    assign pick       = pick_right ? right_reg : slot_rdata;
    assign pick_idx   = pick_right ? PW'(child_r) : PW'(child_r - XW'(1));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                case (mode_reg)
                    MODE_PUSH: begin
                        if (!in_range || is_queued ||
                            (CW + 1)'(count_reg) >= (CW + 1)'(HEAP_DEPTH)) begin
                            state_next = S_RESP;
                        end else begin
                            state_next = S_UP;
                        end
                    end
                    MODE_POP: begin
                        state_next = (count_reg == '0) ? S_RESP : S_POP_ROOT;
                    end
                    MODE_DELETE: begin
                        if (!in_range || !is_queued || count_reg == '0) begin
                            state_next = S_RESP;
                        end else begin
                            state_next = S_DEL_POS;
                        end
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_UP:        state_next = (hole_reg == '0) ? S_PLACE : S_UP_CMP;
            S_UP_CMP: begin
                if (rd_key > cur_key_reg) begin
                    state_next = S_UP;
                end else if (del_first_reg) begin
                    state_next = S_DOWN;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_POP_ROOT:  state_next = S_LOAD_LAST;
            S_DEL_POS:   state_next = S_DEL_SLOT;
            S_DEL_SLOT:  state_next = S_LOAD_LAST;
            S_LOAD_LAST: begin
                if (mode_reg == MODE_DELETE && hole_reg != '0) begin
                    state_next = S_UP_CMP;
                end else begin
                    state_next = S_DOWN;
                end
            end
            S_DOWN: begin
                if (child_r > n_ext) begin
                    state_next = S_PLACE;
                end else if (child_r == n_ext) begin
                    state_next = S_DN_CMP;
                end else begin
                    state_next = S_DN_RIGHT;
                end
            end
            S_DN_RIGHT:  state_next = S_DN_CMP;
            S_DN_CMP:    state_next = (cur_key_reg <= pick[SW-1:HANDLE_W]) ? S_PLACE : S_DOWN;
            S_PLACE:     state_next = S_RESP;
            S_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        mode_next      = mode_reg;
        h_next         = h_reg;
        kin_next       = kin_reg;
        hole_next      = hole_reg;
        cur_key_next   = cur_key_reg;
        cur_h_next     = cur_h_reg;
        count_next     = count_reg;
        res_h_next     = res_h_reg;
        res_k_next     = res_k_reg;
        st_next        = st_reg;
        del_first_next = del_first_reg;
        two_next       = two_reg;
        right_next     = right_reg;
        q_set          = 1'b0;
        q_clr          = 1'b0;
        q_set_idx      = HW'(h_reg);
        q_clr_idx      = HW'(h_reg);
        slot_we        = 1'b0;
        slot_waddr     = hole_reg;
        slot_wdata     = slot_rdata;
        slot_raddr     = parent;
        pos_we         = 1'b0;
        pos_waddr      = HW'(rd_h);
        pos_wdata      = hole_reg;
        pos_raddr      = HW'(h_reg);
        case (state_reg)
            S_IDLE: begin
                mode_next = s_data.mode;
                h_next    = s_data.handle;
                kin_next  = KEY_WIDTH'(s_data.key);
            end
            S_CHECK: begin
                res_h_next     = '0;
                res_k_next     = '0;
                st_next        = ST_OK;
                del_first_next = 1'b0;
                slot_raddr     = '0;
                case (mode_reg)
                    MODE_PUSH: begin
                        if (!in_range) begin
                            st_next = ST_ABSENT;
                        end else if (is_queued) begin
                            st_next = ST_QUEUED;
                        end else if ((CW + 1)'(count_reg) >= (CW + 1)'(HEAP_DEPTH)) begin
                            st_next = ST_FULL;
                        end else begin
                            hole_next    = PW'(count_reg);
                            count_next   = count_reg + CW'(1);
                            cur_key_next = kin_reg;
                            cur_h_next   = h_reg;
                            q_set        = 1'b1;
                        end
                    end
                    MODE_POP: begin
                        if (count_reg == '0) begin
                            st_next = ST_EMPTY;
                        end
                    end
                    MODE_DELETE: begin
                        if (!in_range || !is_queued || count_reg == '0) begin
                            st_next = ST_ABSENT;
                        end
                    end
                    default: st_next = ST_OK;
                endcase
            end
            S_UP: begin
                del_first_next = 1'b0;
            end
            S_UP_CMP: begin
                if (rd_key > cur_key_reg) begin
                    slot_we        = 1'b1;
                    pos_we         = 1'b1;
                    hole_next      = parent;
                    del_first_next = 1'b0;
                end
            end
            S_POP_ROOT: begin
                res_k_next = rd_key;
                res_h_next = rd_h;
                q_clr      = 1'b1;
                q_clr_idx  = HW'(rd_h);
                count_next = count_dec;
                slot_raddr = PW'(count_dec);
                hole_next  = '0;
            end
            S_DEL_POS: begin
                if ((PW + 1)'(pos_rdata) >= (PW + 1)'(HEAP_DEPTH)) begin
                    hole_next = '0;
                end else begin
                    hole_next = pos_rdata;
                end
                slot_raddr = ((PW + 1)'(pos_rdata) >= (PW + 1)'(HEAP_DEPTH)) ? '0 : pos_rdata;
            end
            S_DEL_SLOT: begin
                res_k_next = rd_key;
                res_h_next = h_reg;
                q_clr      = 1'b1;
                count_next = count_dec;
                slot_raddr = PW'(count_dec);
            end
            S_LOAD_LAST: begin
                cur_key_next   = rd_key;
                cur_h_next     = rd_h;
                del_first_next = (mode_reg == MODE_DELETE);
            end
            S_DOWN: begin
                two_next = (child_r < n_ext);
                if (child_r == n_ext) begin
                    slot_raddr = PW'(child_r - XW'(1));
                end else begin
                    slot_raddr = PW'(child_r);
                end
            end
            S_DN_RIGHT: begin
                right_next = slot_rdata;
                slot_raddr = PW'(child_r - XW'(1));
            end
            S_DN_CMP: begin
                if (!(cur_key_reg <= pick[SW-1:HANDLE_W])) begin
                    slot_we    = 1'b1;
                    slot_wdata = pick;
                    pos_we     = 1'b1;
                    pos_waddr  = HW'(pick[HANDLE_W-1:0]);
                    hole_next  = pick_idx;
                end
            end
            S_PLACE: begin
                slot_we    = 1'b1;
                slot_wdata = {cur_key_reg, cur_h_reg};
                pos_we     = 1'b1;
                pos_waddr  = HW'(cur_h_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        h_reg         <= h_next;
        kin_reg       <= kin_next;
        hole_reg      <= hole_next;
        cur_key_reg   <= cur_key_next;
        cur_h_reg     <= cur_h_next;
        res_h_reg     <= res_h_next;
        res_k_reg     <= res_k_next;
        st_reg        <= st_next;
        del_first_reg <= del_first_next;
        two_reg       <= two_next;
        right_reg     <= right_next;
        if (state_reg == S_RESP && (!out_valid_reg || m_ready)) begin
            out_reg.out_handle  <= res_h_reg;
            out_reg.out_key     <= KEY_IN_W'(res_k_reg);
            out_reg.status      <= st_reg;
            out_reg.entry_count <= COUNT_W'(count_reg);
        end
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            queued_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_RESP && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_set) begin
                queued_reg[q_set_idx] <= 1'b1;
            end
            if (q_clr) begin
                queued_reg[q_clr_idx] <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/ihtq_checker.sv
// port-level checks for the timer queue, bound to the top level
// depends on ihtq_pkg and indexed_min_heap_timer_queue_macros.svh
`include "indexed_min_heap_timer_queue_macros.svh"

module ihtq_checker
    import ihtq_pkg::*;
#(
    parameter int HEAP_DEPTH = 256
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    `IHTQ_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))
    `IHTQ_ASSERT_NEXT(a_input_holds, s_valid && !s_ready, s_valid && $stable(s_data))
    `IHTQ_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `IHTQ_ASSERT_NOW(a_count_bound, m_valid, 32'(m_data.entry_count) <= 32'(HEAP_DEPTH))
    `IHTQ_ASSERT_NOW(a_error_zero, m_valid && m_data.status != ST_OK,
        m_data.out_handle == '0 && m_data.out_key == '0)

endmodule

bind indexed_min_heap_timer_queue ihtq_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_ihtq_checker (.*);
